// File: design/mme_pkg.sv
// ---------------------------------------------------------------------------
// mme_pkg
// Shared types and constants for the Montgomery modular exponentiation core.
// ---------------------------------------------------------------------------
package mme_pkg;

    localparam int BASE_W        = 64;
    localparam int MONT_BITS_DEF = 64;
    localparam int CNT_W         = 7;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_BMOD,
        OP_AMONT,
        OP_KSHIFT,
        OP_MSTART,
        OP_MSTEP,
        OP_MFIN,
        OP_EMIT
    } t_op;

    typedef enum logic [1:0] {
        SEL_ACC_A,
        SEL_A_A,
        SEL_ONE
    } t_sel;

    typedef struct packed {
        t_op  op;
        t_sel sel;
    } t_cmd;

    typedef struct packed {
        logic m_even;
        logic k_zero;
        logic k_lsb;
        logic k_hi_zero;
        logic bmod_last;
        logic wbit_last;
    } t_stat;

endpackage

// File: design/mme_dp.sv
// ---------------------------------------------------------------------------
// mme_dp
// Datapath: modulus register, bit-serial reduction, doubling and radix-2
// Montgomery multiplier, exponent shifter and output register.
// ---------------------------------------------------------------------------
module mme_dp
    import mme_pkg::*;
#(
    parameter int MONT_BITS = MONT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [BASE_W-1:0]   i_cfg_data,
    input  logic [2*BASE_W-1:0] i_in_data,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    output logic [BASE_W-1:0]   o_out_data,
    output logic                o_out_err
);
    localparam int W = MONT_BITS;

    logic [BASE_W-1:0] r_modulus;
    logic [W-1:0]      r_m, r_a, r_acc, r_res, r_x, r_y;
    logic [W+1:0]      r_t;
    logic [BASE_W-1:0] r_base, r_k;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_err;
    logic [BASE_W-1:0] r_out_data;
    logic              r_out_err;

    logic [W:0]        w_b2, w_bred, w_a2, w_ared, w_c2, w_cred, w_m1;
    logic [W+1:0]      w_m2, w_s, w_s2, w_fin;
    logic [BASE_W-1:0] w_res64;
    logic [W-1:0]      w_one;

    always_comb begin
        w_one    = '0;
        w_one[0] = 1'b1;
        w_m1     = {1'b0, r_m};
        w_m2     = {2'b00, r_m};
        // base mod m, one bit per cycle from the top
        w_b2     = {r_a, r_base[BASE_W-1]};
        w_bred   = (w_b2 >= w_m1) ? (w_b2 - w_m1) : w_b2;
        w_a2     = {r_a, 1'b0};
        w_ared   = (w_a2 >= w_m1) ? (w_a2 - w_m1) : w_a2;
        w_c2     = {r_acc, 1'b0};
        w_cred   = (w_c2 >= w_m1) ? (w_c2 - w_m1) : w_c2;
        // radix-2 Montgomery step: t = (t + x0*y + q*m) / 2
        w_s      = r_t + (r_x[0] ? {2'b00, r_y} : '0);
        w_s2     = w_s + (w_s[0] ? w_m2 : '0);
        w_fin    = (r_t >= w_m2) ? (r_t - w_m2) : r_t;
        w_res64  = '0;
        w_res64[W-1:0] = r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= {{(BASE_W-1){1'b0}}, 1'b1};
        end else if (i_cfg_we) begin
            r_modulus <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_m    <= r_modulus[W-1:0];
                r_err  <= ~r_modulus[0];
                r_base <= i_in_data[BASE_W-1:0];
                r_k    <= i_in_data[2*BASE_W-1:BASE_W];
                r_a    <= '0;
                r_acc  <= (r_modulus[W-1:0] == w_one) ? '0 : w_one;
                r_cnt  <= '0;
            end
            OP_BMOD: begin
                r_a    <= w_bred[W-1:0];
                r_base <= {r_base[BASE_W-2:0], 1'b0};
                r_cnt  <= o_stat.bmod_last ? '0 : r_cnt + 1'b1;
            end
            OP_AMONT: begin
                // a <- base*R mod m, acc <- R mod m
                r_a   <= w_ared[W-1:0];
                r_acc <= w_cred[W-1:0];
                r_cnt <= o_stat.wbit_last ? '0 : r_cnt + 1'b1;
            end
            OP_KSHIFT: begin
                r_k <= {1'b0, r_k[BASE_W-1:1]};
            end
            OP_MSTART: begin
                r_t   <= '0;
                r_cnt <= '0;
                r_x   <= (i_cmd.sel == SEL_A_A) ? r_a : r_acc;
                r_y   <= (i_cmd.sel == SEL_ONE) ? w_one : r_a;
            end
            OP_MSTEP: begin
                r_t   <= {1'b0, w_s2[W+1:1]};
                r_x   <= {1'b0, r_x[W-1:1]};
                r_cnt <= r_cnt + 1'b1;
            end
            OP_MFIN: begin
                unique case (i_cmd.sel)
                    SEL_ACC_A: r_acc <= w_fin[W-1:0];
                    SEL_A_A:   r_a   <= w_fin[W-1:0];
                    SEL_ONE:   r_res <= w_fin[W-1:0];
                    default:   r_res <= w_fin[W-1:0];
                endcase
            end
            OP_EMIT: begin
                r_out_data <= r_err ? '0 : w_res64;
                r_out_err  <= r_err;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_stat.m_even    = ~r_m[0];
        o_stat.k_zero    = (r_k == '0);
        o_stat.k_lsb     = r_k[0];
        o_stat.k_hi_zero = (r_k[BASE_W-1:1] == '0);
        o_stat.bmod_last = (r_cnt == CNT_W'(BASE_W - 1));
        o_stat.wbit_last = (r_cnt == CNT_W'(W - 1));
    end

    assign o_out_data = r_out_data;
    assign o_out_err  = r_out_err;

endmodule

// File: design/mme_ctrl.sv
// ---------------------------------------------------------------------------
// mme_ctrl
// Sequencer: steps the datapath through reduction, conversion, the
// exponent scan and the Montgomery products; owns the handshakes.
// ---------------------------------------------------------------------------
module mme_ctrl
    import mme_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    output logic  o_s_tready,
    output logic  o_m_tvalid,
    input  logic  i_m_tready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_CHK    = 10'b0000000010,
        S_BMOD   = 10'b0000000100,
        S_AMONT  = 10'b0000001000,
        S_EBIT   = 10'b0000010000,
        S_SQ     = 10'b0000100000,
        S_MSTART = 10'b0001000000,
        S_MSTEP  = 10'b0010000000,
        S_MFIN   = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    t_sel   r_sel, n_sel;
    logic   r_ovalid, n_ovalid;

    always_comb begin
        n_state    = r_state;
        n_sel      = r_sel;
        n_ovalid   = r_ovalid && !i_m_tready;
        o_cmd.op   = OP_NONE;
        o_cmd.sel  = r_sel;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_CHK;
                end
            end
            S_CHK: begin
                n_state = i_stat.m_even ? S_OUT : S_BMOD;
            end
            S_BMOD: begin
                o_cmd.op = OP_BMOD;
                if (i_stat.bmod_last) n_state = S_AMONT;
            end
            S_AMONT: begin
                o_cmd.op = OP_AMONT;
                if (i_stat.wbit_last) n_state = S_EBIT;
            end
            S_EBIT: begin
                if (i_stat.k_zero) begin
                    n_sel   = SEL_ONE;
                    n_state = S_MSTART;
                end else if (i_stat.k_lsb) begin
                    n_sel   = SEL_ACC_A;
                    n_state = S_MSTART;
                end else begin
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                o_cmd.op = OP_KSHIFT;
                if (i_stat.k_hi_zero) begin
                    n_state = S_EBIT;
                end else begin
                    n_sel   = SEL_A_A;
                    n_state = S_MSTART;
                end
            end
            S_MSTART: begin
                o_cmd.op = OP_MSTART;
                n_state  = S_MSTEP;
            end
            S_MSTEP: begin
                o_cmd.op = OP_MSTEP;
                if (i_stat.wbit_last) n_state = S_MFIN;
            end
            S_MFIN: begin
                o_cmd.op = OP_MFIN;
                unique case (r_sel)
                    SEL_ACC_A: n_state = S_SQ;
                    SEL_A_A:   n_state = S_EBIT;
                    SEL_ONE:   n_state = S_OUT;
                    default:   n_state = S_OUT;
                endcase
            end
            S_OUT: begin
                if (!r_ovalid || i_m_tready) begin
                    o_cmd.op = OP_EMIT;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sel    <= SEL_ONE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sel    <= n_sel;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_m_tvalid = r_ovalid;

endmodule

// File: design/montgomery_modexp_core.sv
// ---------------------------------------------------------------------------
// montgomery_modexp_core
// base^exponent mod M with a bit-serial radix-2 Montgomery multiplier.
// ---------------------------------------------------------------------------
// Channel  | Dir | Payload
// s        | in  | tdata[63:0] base, tdata[127:64] exponent
// m        | out | tdata[63:0] power_result, tuser modulus_error
// cfg      | in  | data[63:0] modulus
//
// One item at a time: a modulus check, base reduction and conversion, then
// one Montgomery product per exponent bit below the top set bit for the
// square, one per set bit and one for the final conversion; the products
// all share one bit-serial multiplier. Even modulus: zero result with the
// error flag set, and no products. Reset is synchronous, active low.
// The result waits in an output register; a stalled output holds only the
// next result, not input acceptance of the following item.
// ---------------------------------------------------------------------------
module montgomery_modexp_core
    import mme_pkg::*;
#(
    parameter int MONT_BITS = MONT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [2*BASE_W-1:0] i_s_tdata,   // base, exponent
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [BASE_W-1:0]   o_m_tdata,   // power_result
    output logic                o_m_tuser,   // modulus_error
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [BASE_W-1:0]   i_cfg_data
);
    t_cmd  w_cmd;
    t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    mme_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    mme_dp #(.MONT_BITS(MONT_BITS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_in_data  (i_s_tdata),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_out_data (o_m_tdata),
        .o_out_err  (o_m_tuser)
    );

endmodule

// File: design/mme_checker.sv
// ---------------------------------------------------------------------------
// mme_checker
// Port-level checks for montgomery_modexp_core.
// ---------------------------------------------------------------------------
module mme_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [63:0]  o_m_tdata,
    input logic         o_m_tuser,
    input logic         o_cfg_ready
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == 64'd0)
        else $error("error result not zero");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second item taken while busy");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config port not ready");

endmodule

bind montgomery_modexp_core mme_checker u_mme_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_s_tvalid  (i_s_tvalid),
    .o_s_tready  (o_s_tready),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata),
    .o_m_tuser   (o_m_tuser),
    .o_cfg_ready (o_cfg_ready)
);
